// ===== src/bf_pkg.sv =====
// Shared types, constants and control program for the Blowfish block encrypt engine.
`default_nettype none

package bf_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int ROUNDS  = 16;
    localparam int RND_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    localparam int P_DEPTH  = ROUNDS + 2;
    localparam int P_IDX_W  = $clog2(P_DEPTH);
    localparam int S_BOXES  = 4;
    localparam int S_DEPTH  = 256;
    localparam int S_ADDR_W = $clog2(S_DEPTH);
    localparam int BOX_W    = $clog2(S_BOXES);

    localparam int ACT_W   = 2;
    localparam int IDX_W   = 10;

    localparam int IDX_LSB   = 0;
    localparam int WORD_LSB  = IDX_LSB + IDX_W;
    localparam int LEFT_LSB  = WORD_LSB + WORD_W;
    localparam int RIGHT_LSB = LEFT_LSB + WORD_W;
    localparam int IN_BITS   = RIGHT_LSB + WORD_W;

    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 8;
    localparam int OUT_TDATA_W = 2 * WORD_W;

    localparam logic [ACT_W-1:0] ACT_LOAD_P  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_S  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ENCRYPT = 2'd2;

    localparam int STEP_W = 2;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT    = 2'd0;
    localparam step_t STEP_MIX     = 2'd1;
    localparam step_t STEP_FEISTEL = 2'd2;
    localparam step_t STEP_EMIT    = 2'd3;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_START,
        COND_MORE,
        COND_OBUSY
    } cond_t;

    typedef struct packed {
        logic  accept;
        logic  mix;
        logic  feistel;
        logic  emit;
        cond_t cond;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '0;
        unique case (step)
            STEP_WAIT:
            begin
                w.accept = 1'b1;
                w.cond   = COND_NO_START;
                w.target = STEP_WAIT;
            end
            STEP_MIX:
            begin
                w.mix    = 1'b1;
                w.cond   = COND_NONE;
                w.target = STEP_WAIT;
            end
            STEP_FEISTEL:
            begin
                w.feistel = 1'b1;
                w.cond    = COND_MORE;
                w.target  = STEP_MIX;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_OBUSY;
                w.target = STEP_EMIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/bf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/blowfish_block_encrypt.sv =====
// Top level of the Blowfish 64-bit block encrypt engine with host-loaded subkeys.
`default_nettype none

// Each input transfer carries an action in s_tuser: load one P-array word, load one
// S-box word, or encrypt a left/right block. Loads give no output; P indexes above 17
// are dropped. An encryption runs from its transfer through the wait step that accepts
// it, then for each of 16 rounds a mix step that forms the S-box addresses and a Feistel
// step on the registered reads of the four S-box RAMs and the F combine, then the output
// step into the output register. One block is in flight at a time; a new transfer is
// taken once the previous result sits in the output register.
// Tables must be loaded before they are used; they are not cleared at reset.
module blowfish_block_encrypt (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // table_index[9:0], table_word[41:10], left_half[73:42], right_half[105:74]
    input  wire logic [bf_pkg::IN_TDATA_W-1:0]    s_tdata,
    // action[1:0]
    input  wire logic [bf_pkg::IN_TUSER_W-1:0]    s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // left_out[31:0], right_out[63:32]
    output logic      [bf_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    import bf_pkg::*;

    ucode_t              uc;
    step_t               pc_reg, pc_next;
    logic [RND_W-1:0]    rnd_reg, rnd_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0]   l_reg, l_next;
    logic [WORD_W-1:0]   r_reg, r_next;
    logic [WORD_W-1:0]   left_out_reg, left_out_next;
    logic [WORD_W-1:0]   right_out_reg, right_out_next;
    logic [WORD_W-1:0]   p_key_reg [P_DEPTH];

    logic                in_xfer;
    logic                start;
    logic                obusy;
    logic                cond_true;
    logic                p_we;
    logic [ACT_W-1:0]    action;
    logic [IDX_W-1:0]    table_index;
    logic [WORD_W-1:0]   table_word;
    logic [WORD_W-1:0]   left_half;
    logic [WORD_W-1:0]   right_half;
    logic [WORD_W-1:0]   l_mix;
    logic [WORD_W-1:0]   sum01;
    logic [WORD_W-1:0]   f_val;
    logic [WORD_W-1:0]   s_rd [S_BOXES];

    assign uc          = ucode_rom(pc_reg);
    assign s_tready    = uc.accept;
    assign in_xfer     = s_tvalid && s_tready;
    assign action      = s_tuser[ACT_W-1:0];
    assign table_index = s_tdata[IDX_LSB +: IDX_W];
    assign table_word  = s_tdata[WORD_LSB +: WORD_W];
    assign left_half   = s_tdata[LEFT_LSB +: WORD_W];
    assign right_half  = s_tdata[RIGHT_LSB +: WORD_W];

    assign start = in_xfer && (action == ACT_ENCRYPT);
    assign p_we  = in_xfer && (action == ACT_LOAD_P) && (table_index < IDX_W'(P_DEPTH));
    assign obusy = m_tvalid_reg && !m_tready;

    assign l_mix = l_reg ^ p_key_reg[P_IDX_W'(rnd_reg)];
    assign sum01 = s_rd[0] + s_rd[1];
    assign f_val = (sum01 ^ s_rd[2]) + s_rd[3];

    genvar g;
    generate
        for (g = 0; g < S_BOXES; g++)
        begin : g_sbox
            bf_ram #(
                .WIDTH (WORD_W),
                .DEPTH (S_DEPTH)
            ) u_sbox (
                .clk     (clk),
                .wr_en   (in_xfer && (action == ACT_LOAD_S) &&
                          (table_index[IDX_W-1 -: BOX_W] == BOX_W'(g))),
                .wr_addr (table_index[S_ADDR_W-1:0]),
                .wr_data (table_word),
                .rd_addr (l_mix[BYTE_W*(S_BOXES-1-g) +: BYTE_W]),
                .rd_data (s_rd[g])
            );
        end
    endgenerate

    always_comb
    begin
        unique case (uc.cond)
            COND_NONE:     cond_true = 1'b0;
            COND_NO_START: cond_true = !start;
            COND_MORE:     cond_true = (rnd_reg != RND_W'(ROUNDS - 1));
            COND_OBUSY:    cond_true = obusy;
        endcase
    end

    always_comb
    begin
        pc_next        = cond_true ? uc.target : step_t'(pc_reg + 1'b1);
        rnd_next       = rnd_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        m_tvalid_next  = m_tvalid_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;

        if (start)
        begin
            l_next   = left_half;
            r_next   = right_half;
            rnd_next = '0;
        end
        if (uc.mix)
        begin
            l_next = l_mix;
        end
        if (uc.feistel)
        begin
            l_next   = r_reg ^ f_val;
            r_next   = l_reg;
            rnd_next = RND_W'(rnd_reg + 1'b1);
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        // final swap is undone by taking r as left
        if (uc.emit && !obusy)
        begin
            m_tvalid_next  = 1'b1;
            left_out_next  = r_reg ^ p_key_reg[P_IDX_W'(ROUNDS + 1)];
            right_out_next = l_reg ^ p_key_reg[P_IDX_W'(ROUNDS)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= STEP_WAIT;
            rnd_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            pc_reg       <= pc_next;
            rnd_reg      <= rnd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg         <= l_next;
        r_reg         <= r_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        if (p_we)
        begin
            p_key_reg[table_index[P_IDX_W-1:0]] <= table_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {right_out_reg, left_out_reg};

`ifndef ASSERT_OFF
    a_start_enters_round: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (pc_reg == STEP_MIX) && (rnd_reg == '0))
        else $error("encrypt transfer did not start round zero");

    a_emit_after_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_EMIT) && ($past(pc_reg) == STEP_FEISTEL)
        |-> $past(rnd_reg) == RND_W'(ROUNDS - 1))
        else $error("output step reached before last round");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(pc_reg) == STEP_EMIT)
        else $error("output valid raised outside output step");

    a_feistel_after_mix: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_FEISTEL) |-> $past(pc_reg) == STEP_MIX)
        else $error("round combine without address step");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the Blowfish block encrypt engine: loads, encryptions, ignored items.
`timescale 1ns / 100ps

module testbench;

    import bf_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int S_TOTAL    = S_BOXES * S_DEPTH;
    localparam int CYCLE_CAP  = 400000;
    localparam int IDLE_PCT   = 8;
    localparam int TAIL_WAIT  = 40;
    localparam int RAND_ITEMS = 64;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [WORD_W-1:0] right;
        logic [WORD_W-1:0] left;
    } cipher_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic [IN_TUSER_W-1:0]   s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    logic [WORD_W-1:0] pkey_mem [P_DEPTH];
    logic [WORD_W-1:0] sbox_mem [S_TOTAL];
    cipher_t           cipher_q [$];
    cipher_t           want_c;
    cipher_t           got_c;

    bit quiet = 1'b0;
    int cycle_count = 0;
    int mismatches = 0;
    int blocks_checked = 0;
    int n_loads = 0;
    int n_encrypts = 0;
    int n_ignored = 0;

    blowfish_block_encrypt u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    function automatic logic [WORD_W-1:0] mix_f(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = sbox_mem[{2'd0, x[31:24]}] + sbox_mem[{2'd1, x[23:16]}];
        y = y ^ sbox_mem[{2'd2, x[15:8]}];
        return y + sbox_mem[{2'd3, x[7:0]}];
    endfunction

    function automatic cipher_t predict_cipher(input logic [WORD_W-1:0] l_in,
                                               input logic [WORD_W-1:0] r_in);
        logic [WORD_W-1:0] l;
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] t;
        cipher_t c;
        l = l_in;
        r = r_in;
        for (int i = 0; i < ROUNDS; i++)
        begin
            l = l ^ pkey_mem[i];
            r = r ^ mix_f(l);
            t = l;
            l = r;
            r = t;
        end
        // undo last swap, then whitening
        c.left  = r ^ pkey_mem[ROUNDS + 1];
        c.right = l ^ pkey_mem[ROUNDS];
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input cipher_t want, input cipher_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] %s: expected L=%08h R=%08h, got L=%08h R=%08h",
                     $realtime, what, want.left, want.right, got.left, got.right);
    endtask

    // one input transfer; model updated at the accepting edge
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] l,
                             input logic [WORD_W-1:0] r);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, r, l, word, idx};
        s_tuser  <= {{(IN_TUSER_W - ACT_W){1'b0}}, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (act)
            ACT_LOAD_P:
            begin
                if (idx < P_DEPTH)
                begin
                    pkey_mem[idx] = word;
                    n_loads++;
                end
                else
                    n_ignored++;
            end
            ACT_LOAD_S:
            begin
                sbox_mem[idx] = word;
                n_loads++;
            end
            ACT_ENCRYPT:
            begin
                cipher_q.push_back(predict_cipher(l, r));
                n_encrypts++;
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic encrypt_block(input logic [WORD_W-1:0] l, input logic [WORD_W-1:0] r);
        send_item(ACT_ENCRYPT, IDX_W'($urandom), $urandom, l, r);
    endtask

    // every table entry written before any encryption reads it
    task automatic test_table_fill();
        for (int i = 0; i < P_DEPTH; i++)
            send_item(ACT_LOAD_P, IDX_W'(i), rand_word(), $urandom, $urandom);
        for (int i = 0; i < S_TOTAL; i++)
            send_item(ACT_LOAD_S, IDX_W'(i), rand_word(), $urandom, $urandom);
    endtask

    task automatic test_directed_edges();
        encrypt_block('0, '0);
        encrypt_block('1, '1);
        encrypt_block('0, '1);
        encrypt_block('1, '0);
        encrypt_block(32'hAAAA_AAAA, 32'h5555_5555);
        // last whitening key rewritten
        send_item(ACT_LOAD_P, IDX_W'(P_DEPTH - 1), '1, '0, '0);
        send_item(ACT_LOAD_P, IDX_W'(0), '0, '1, '1);
        encrypt_block(32'h0123_4567, 32'h89AB_CDEF);
        // out-of-range P indexes must not land anywhere
        send_item(ACT_LOAD_P, IDX_W'(P_DEPTH), '1, '1, '1);
        send_item(ACT_LOAD_P, '1, '0, '0, '0);
        encrypt_block(32'h0123_4567, 32'h89AB_CDEF);
        send_item(ACT_LOAD_S, '0, '1, '0, '0);
        send_item(ACT_LOAD_S, '1, '0, '1, '1);
        encrypt_block('0, '1);
        // unused action code
        send_item(ACT_UNUSED, '1, '1, '1, '1);
        send_item(ACT_UNUSED, '0, '0, '0, '0);
        encrypt_block('1, '0);
        wait_drained();
    endtask

    // sender holds off until the pipe is empty, then pushes back to back
    task automatic test_drain_pause();
        bit saved;
        saved = quiet;
        for (int i = 0; i < 3; i++)
            encrypt_block($urandom, $urandom);
        wait_drained();
        quiet = 1'b1;
        for (int i = 0; i < 4; i++)
            encrypt_block($urandom, $urandom);
        send_item(ACT_LOAD_S, IDX_W'($urandom), $urandom, $urandom, $urandom);
        encrypt_block($urandom, $urandom);
        quiet = saved;
        wait_drained();
    endtask

    task automatic test_random_mix();
        int sel;
        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            quiet = (k >= RAND_ITEMS / 4 && k < 3 * RAND_ITEMS / 4);
            sel = $urandom_range(0, 99);
            if (sel < 45)
                encrypt_block(rand_word(), rand_word());
            else if (sel < 70)
                send_item(ACT_LOAD_S, IDX_W'($urandom), rand_word(), $urandom, $urandom);
            else if (sel < 85)
                send_item(ACT_LOAD_P, IDX_W'($urandom_range(0, P_DEPTH - 1)), rand_word(),
                          $urandom, $urandom);
            else if (sel < 93)
                send_item(ACT_LOAD_P, IDX_W'($urandom_range(P_DEPTH, 1023)), $urandom,
                          $urandom, $urandom);
            else
                send_item(ACT_UNUSED, IDX_W'($urandom), $urandom, $urandom, $urandom);
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles, %0d blocks outstanding",
                     cycle_count, cipher_q.size());
            $display("Simulation FAILED");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got_c = m_tdata;
            if (cipher_q.size() == 0)
                report_mismatch("output transfer with nothing pending", '0, got_c);
            else
            begin
                want_c = cipher_q.pop_front();
                blocks_checked++;
                if (got_c.left !== want_c.left || got_c.right !== want_c.right)
                    report_mismatch("ciphertext mismatch", want_c, got_c);
            end
        end
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_fill();
        test_directed_edges();
        test_drain_pause();
        test_random_mix();
        repeat (TAIL_WAIT) @(posedge clk);
        if (cipher_q.size() != 0)
        begin
            $display("%0d expected blocks never arrived", cipher_q.size());
            mismatches += cipher_q.size();
        end
        $display("Ran %0d table loads, %0d encryptions and %0d ignored items",
                 n_loads, n_encrypts, n_ignored);
        $display("Checked %0d ciphertext blocks, %0d mismatches", blocks_checked, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/bf_pkg.sv
src/bf_ram.sv
src/blowfish_block_encrypt.sv
tb/testbench.sv
